/* hdl/stereo_flanger_unit_macros.svh */
// ----------------------------------------------------------------------------
// Stereo flanger assertion macros
// Concurrent checks shared by the flanger RTL, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_FLANGER_UNIT_MACROS_SVH
`define STEREO_FLANGER_UNIT_MACROS_SVH

// same-cycle implication
`define SFU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sfu_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo flanger package
// Widths, register codes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sfu_pkg;

  localparam int SampleBits   = 24;
  localparam int LineDepthDef = 4096;

  // quarter-wave sine ROM, power-of-two size
  localparam int SineBits     = 10;
  localparam int SineEntries  = 1 << SineBits;
  localparam int SineW        = 16;

  localparam int PhaseW       = 32;
  localparam int StepW        = 31;
  localparam int DelayCfgW    = 20;
  localparam int FbW          = 16;
  localparam int MixW         = 17;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 31;

  // shared multiplier: signed 26 x 18
  localparam int MulAW        = 26;
  localparam int MulBW        = 18;
  localparam int ProdW        = MulAW + MulBW;
  localparam int DelayCalcW   = 25;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_MOD_DEPTH    = 3'd1,
    REG_MANUAL_DELAY = 3'd2,
    REG_MIN_DELAY    = 3'd3,
    REG_FEEDBACK     = 3'd4,
    REG_MIX          = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINE,
    ST_MOD,
    ST_DELAY,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_WET,
    ST_FB,
    ST_STORE,
    ST_OUTC,
    ST_WRITE,
    ST_PUT
  } sfu_state_e;

  // round(32767*sin(pi/2*(k+0.5)/SineEntries)) via Q30 odd polynomial
  function automatic logic [SineW-1:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned v;
    x  = (64'(2 * k + 1) << 29) >> SineBits;
    x2 = (x * x) >> 30;
    r  = 64'd85569306 - ((64'd5026995 * x2) >> 30);
    r  = 64'd693598668 - ((r * x2) >> 30);
    r  = 64'd1686629713 - ((r * x2) >> 30);
    v  = (r * x) >> 30;
    v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return SineW'(v);
  endfunction

  function automatic logic signed [SampleBits-1:0] saturate(
    input logic signed [ProdW-1:0] v
  );
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'((longint'(1) <<< (SampleBits - 1)) - 1);
    lo = -hi - ProdW'(1);
    if (v > hi) return hi[SampleBits-1:0];
    if (v < lo) return lo[SampleBits-1:0];
    return v[SampleBits-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/stereo_flanger_unit.sv */
// ----------------------------------------------------------------------------
// Stereo flanger
// One beat in is one stereo frame (left in the low 24 bits, right above it);
// one beat out is the processed frame in the same layout. Per frame a shared
// LFO phase advances, picks a sine value from a quarter-wave ROM and sets a
// fractional delay (Q.8 samples) that taps both delay lines with linear
// interpolation; each line stores input plus fed-back wet signal and the
// output is a wet/dry mix, both saturated to 24 bits. Per frame one 26x18
// multiplier is used seven times (modulation, then per channel
// interpolation, feedback and mix) and the single-port delay memory is
// read twice. Frames are taken one at a time; a finished frame may sit in
// the output register while the next one is accepted. The delay lines read
// as zero until written, with no clearing pass after reset. Registers are
// to be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_flanger_unit_macros.svh"

module stereo_flanger_unit
  import sfu_pkg::*;
#(
  parameter int LINE_DEPTH = LineDepthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [2*SampleBits-1:0] s_axis_tdata,   // left_in, right_in
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [2*SampleBits-1:0]      m_axis_tdata,   // left_out, right_out
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgDataW-1:0]     cfg_wdata_i
);

  localparam int AddrW = $clog2(LINE_DEPTH);
  localparam int DelayW = AddrW + 8;
  localparam int PosW = AddrW + 9;
  localparam int RowW = 2 * SampleBits;
  localparam logic [DelayCalcW-1:0] MaxDelay = DelayCalcW'(LINE_DEPTH * 256 - 1);
  localparam logic [AddrW:0] DepthExt = (AddrW + 1)'(LINE_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(LINE_DEPTH - 1);

  // configuration
  logic [StepW-1:0]        phase_step_q;
  logic [DelayCfgW-1:0]    mod_depth_q;
  logic [DelayCfgW-1:0]    manual_delay_q;
  logic [DelayCfgW-1:0]    min_delay_q;
  logic signed [FbW-1:0]   feedback_q;
  logic [MixW-1:0]         mix_q;

  // control
  sfu_state_e              state_q, state_d;
  logic [PhaseW-1:0]       phase_q;
  logic [AddrW-1:0]        wp_q;
  logic                    wrapped_q;
  logic                    ch_q;
  logic                    out_valid_q, out_valid_d;

  // datapath
  logic signed [SampleBits-1:0] x_q [2];
  logic [SineW-1:0]             sine_mag_q;
  logic signed [ProdW-1:0]      prod_q, prod_d;
  logic [DelayW-1:0]            delay_q;
  logic [AddrW-1:0]             idx0_q, idx1_q, idx0_d, idx1_d;
  logic [7:0]                   frac_q;
  logic [RowW-1:0]              rd_q;
  logic                         rd_valid_q;
  logic [RowW-1:0]              a_row_q;
  logic signed [SampleBits-1:0] wet_q, wet_d;
  logic signed [SampleBits-1:0] stored_q [2];
  logic signed [SampleBits-1:0] y_q [2];
  logic [RowW-1:0]              out_data_q;

  logic [RowW-1:0]              line_mem [LINE_DEPTH];
  logic [SineW-1:0]             sine_rom [SineEntries];

  logic                         accept;
  logic                         out_load;
  logic                         mem_rd;
  logic [AddrW-1:0]             rd_addr;

  logic [SineBits-1:0]          sine_idx;
  logic signed [MulBW-1:0]      s_mag, s_off;
  logic [MixW-1:0]              mix_eff;
  logic signed [SampleBits-1:0] x_sel, a_sel, b_sel;
  logic [RowW-1:0]              b_row;
  logic signed [MulAW-1:0]      mul_a;
  logic signed [MulBW-1:0]      mul_b;
  logic signed [MulAW-1:0]      wet_calc;
  logic signed [ProdW-1:0]      fb_acc, mix_acc;
  logic signed [SampleBits-1:0] stored_val, y_val;
  logic [DelayCfgW-1:0]         mod_val;
  logic [DelayCalcW-1:0]        dsum, dmax, dclamp;
  logic [PosW-1:0]              pos;
  logic [AddrW:0]               tap;

  for (genvar k = 0; k < SineEntries; k++) begin : g_rom
    assign sine_rom[k] = quarter_sine(k);
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= StepW'(22370);
      mod_depth_q    <= DelayCfgW'(34406);
      manual_delay_q <= DelayCfgW'(18432);
      min_delay_q    <= DelayCfgW'(1229);
      feedback_q     <= FbW'(16384);
      mix_q          <= MixW'(32768);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i[StepW-1:0];
        REG_MOD_DEPTH:    mod_depth_q    <= cfg_wdata_i[DelayCfgW-1:0];
        REG_MANUAL_DELAY: manual_delay_q <= cfg_wdata_i[DelayCfgW-1:0];
        REG_MIN_DELAY:    min_delay_q    <= cfg_wdata_i[DelayCfgW-1:0];
        REG_FEEDBACK:     feedback_q     <= cfg_wdata_i[FbW-1:0];
        REG_MIX:          mix_q          <= cfg_wdata_i[MixW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- combinational
  always_comb begin
    // quadrant mirror on phase bit 30, negate on bit 31
    sine_idx = phase_q[30] ? ~phase_q[PhaseW-3 -: SineBits] : phase_q[PhaseW-3 -: SineBits];
    s_mag    = $signed({2'b00, sine_mag_q});
    s_off    = MulBW'(32768) + (phase_q[PhaseW-1] ? -s_mag : s_mag);
    mix_eff  = mix_q[MixW-1] ? {1'b1, {(MixW-1){1'b0}}} : mix_q;

    x_sel = x_q[ch_q];
    b_row = rd_valid_q ? rd_q : '0;
    a_sel = ch_q ? $signed(a_row_q[RowW-1:SampleBits]) : $signed(a_row_q[SampleBits-1:0]);
    b_sel = ch_q ? $signed(b_row[RowW-1:SampleBits]) : $signed(b_row[SampleBits-1:0]);

    // delay in Q.8 samples
    mod_val = prod_q[DelayCfgW+15:16];
    dsum    = DelayCalcW'(manual_delay_q) + DelayCalcW'(mod_val);
    dmax    = (dsum < DelayCalcW'(min_delay_q)) ? DelayCalcW'(min_delay_q) : dsum;
    dclamp  = (dmax > MaxDelay) ? MaxDelay : dmax;

    // tap position behind the write pointer, one compare-subtract wraps it
    pos    = {({1'b0, wp_q} + DepthExt), 8'b0} - PosW'(delay_q);
    tap    = pos[PosW-1:8];
    idx0_d = (tap >= DepthExt) ? AddrW'(tap - DepthExt) : tap[AddrW-1:0];
    idx1_d = (idx0_d == LastAddr) ? '0 : idx0_d + 1'b1;

    // shared multiplier operands
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MOD: begin
        mul_a = $signed({{(MulAW-DelayCfgW){1'b0}}, mod_depth_q});
        mul_b = s_off;
      end
      ST_INTERP: begin
        mul_a = MulAW'(b_sel) - MulAW'(a_sel);
        mul_b = $signed({{(MulBW-8){1'b0}}, frac_q});
      end
      ST_FB: begin
        mul_a = MulAW'(wet_q);
        mul_b = MulBW'(feedback_q);
      end
      ST_STORE: begin
        mul_a = MulAW'(wet_q) - MulAW'(x_sel);
        mul_b = $signed({{(MulBW-MixW){1'b0}}, mix_eff});
      end
      default: ;
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);

    // a + floor((b-a)*frac/256)
    wet_calc = MulAW'(a_sel) + MulAW'(prod_q >>> 8);
    wet_d    = wet_calc[SampleBits-1:0];

    fb_acc     = ((prod_q + (ProdW'(1) <<< 14)) >>> 15) + ProdW'(x_sel);
    stored_val = saturate(fb_acc);

    // x*(1-mix) + wet*mix == x*2^16 + (wet-x)*mix
    mix_acc = (prod_q + (ProdW'(x_sel) <<< 16) + (ProdW'(1) <<< 15)) >>> 16;
    y_val   = saturate(mix_acc);
  end

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_rd        = 1'b0;
    rd_addr       = idx0_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_SINE;
      end
      ST_SINE:   state_d = ST_MOD;
      ST_MOD:    state_d = ST_DELAY;
      ST_DELAY:  state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_RD0;
      ST_RD0: begin
        mem_rd  = 1'b1;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        mem_rd  = 1'b1;
        rd_addr = idx1_q;
        state_d = ST_INTERP;
      end
      ST_INTERP: state_d = ST_WET;
      ST_WET:    state_d = ST_FB;
      ST_FB:     state_d = ST_STORE;
      ST_STORE:  state_d = ST_OUTC;
      ST_OUTC:   state_d = ch_q ? ST_WRITE : ST_INTERP;
      ST_WRITE:  state_d = ST_PUT;
      ST_PUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) phase_q <= phase_q + {1'b0, phase_step_q};
      if (state_q == ST_OUTC) ch_q <= ~ch_q;
      if (state_q == ST_WRITE) begin
        wp_q <= (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
        if (wp_q == LastAddr) wrapped_q <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      x_q[0] <= s_axis_tdata[SampleBits-1:0];
      x_q[1] <= s_axis_tdata[RowW-1:SampleBits];
    end
    if (state_q == ST_SINE)  sine_mag_q <= sine_rom[sine_idx];
    if (state_q == ST_DELAY) delay_q <= dclamp[DelayW-1:0];
    if (state_q == ST_ADDR) begin
      idx0_q <= idx0_d;
      idx1_q <= idx1_d;
      frac_q <= pos[7:0];
    end
    // rows never written since reset read as zero
    if (mem_rd) rd_valid_q <= wrapped_q || (rd_addr < wp_q);
    if (state_q == ST_RD1)   a_row_q <= rd_valid_q ? rd_q : '0;
    if (state_q == ST_WET)   wet_q <= wet_d;
    if (state_q == ST_STORE) stored_q[ch_q] <= stored_val;
    if (state_q == ST_OUTC)  y_q[ch_q] <= y_val;
    if (out_load)            out_data_q <= {y_q[1], y_q[0]};
  end

  // delay lines, both channels in one row
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) line_mem[wp_q] <= {stored_q[1], stored_q[0]};
    if (mem_rd) rd_q <= line_mem[rd_addr];
  end

  // ------------------------------------------------------------- assertions
  `SFU_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready, "frame accepted while busy")
  `SFU_ASSERT_NOW(a_wp_in_range, 1'b1, wp_q <= LastAddr, "write pointer past line end")
  `SFU_ASSERT_NOW(a_tap0_in_range, state_q == ST_RD0, idx0_q <= LastAddr, "tap past line end")
  `SFU_ASSERT_NOW(a_tap1_in_range, state_q == ST_RD0, idx1_q <= LastAddr, "tap past line end")
  `SFU_ASSERT_NOW(a_channel_done, state_q == ST_PUT, ch_q == 1'b0, "channel not back at left")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Stereo flanger testbench
// Drives stereo frames into stereo_flanger_unit with random gaps and output
// stalls, and holds its own copy of the LFO, delay lines and registers to
// predict each output frame. The run starts with a short list of hand-picked
// frames and register writes. Random phases with fresh register settings
// follow, then one longer phase and short runs at the delay extremes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfu_pkg::*;

  localparam int     LineLen     = LineDepthDef;
  localparam longint DelayCap    = longint'(LineLen) * 256 - 1;
  localparam longint SampleHi    = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint SampleLo    = -SampleHi - 1;
  localparam int     CycleLimit  = 800000;
  localparam int     DrainCycles = 50;
  localparam int     PhaseCount  = 10;
  localparam int     PhaseFrames = 120;
  localparam int     WrapFrames  = 400;
  localparam int     TailFrames  = 40;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE7 = 3'd7;

  localparam logic signed [SampleBits-1:0] S_MAX  = 24'sh7FFFFF;
  localparam logic signed [SampleBits-1:0] S_MIN  = 24'sh800000;
  localparam logic signed [SampleBits-1:0] S_HPOS = 24'sh400000;
  localparam logic signed [SampleBits-1:0] S_HNEG = 24'shC00000;

  // left in the low bits, as on tdata
  typedef struct packed {
    logic signed [SampleBits-1:0] right;
    logic signed [SampleBits-1:0] left;
  } stereo_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    stereo_t             din;
    logic                typed;
    stereo_t             dout;
  } step_row_t;

  // frames written as {right, left}
  localparam int DirRows = 42;
  localparam step_row_t DirectedSteps [DirRows] = '{
    // reset settings, empty lines: output is half the input, ties round up
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MAX}, 1'b1, {S_HNEG, S_HPOS}},
    '{1'b0, REG_PHASE_STEP, 31'd0, {-24'sd1, 24'sd1}, 1'b1, {24'sd0, 24'sd1}},
    '{1'b0, REG_PHASE_STEP, 31'd0, {-24'sd3, 24'sd3}, 1'b1, {-24'sd1, 24'sd2}},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MIN}, 1'b1, {S_HPOS, S_HNEG}},
    '{1'b0, REG_PHASE_STEP, 31'd0, 48'd0, 1'b1, 48'd0},
    // fully wet, then wet above one
    '{1'b1, REG_MIX, 31'd65536, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MAX}, 1'b1, 48'd0},
    '{1'b1, REG_MIX, 31'd131071, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MIN}, 1'b1, 48'd0},
    // dry
    '{1'b1, REG_MIX, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MAX}, 1'b1, {S_MIN, S_MAX}},
    // writes to unused indexes must not disturb anything
    '{1'b1, REG_SPARE6, 31'h7FFFFFFF, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_SPARE7, 31'h7FFFFFFF, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {24'sh123456, 24'shABCDEF}, 1'b1,
      {24'sh123456, 24'shABCDEF}},
    // one-sample delay with feedback beyond the nominal range
    '{1'b1, REG_MOD_DEPTH, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MIN_DELAY, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MANUAL_DELAY, 31'd256, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_FEEDBACK, 31'h7FFF, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MIX, 31'd65536, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MAX}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MAX}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MAX}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MAX}, 1'b0, 48'd0},
    '{1'b1, REG_FEEDBACK, 31'h7FFF8000, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MAX}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MAX}, 1'b0, 48'd0},
    // tap at the write position, then half a sample
    '{1'b1, REG_MANUAL_DELAY, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {24'sd1000, -24'sd1000}, 1'b0, 48'd0},
    '{1'b1, REG_MANUAL_DELAY, 31'd128, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MIX, 31'd40000, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MAX, S_MIN}, 1'b0, 48'd0},
    // delay far past the line length, fastest LFO
    '{1'b1, REG_MANUAL_DELAY, 31'hFFFFF, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MOD_DEPTH, 31'hFFFFF, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_PHASE_STEP, 31'h7FFFFFFF, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {24'sh5A5A5A, 24'sh2A5A5A}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {24'shA5A5A5, 24'shD5A5A5}, 1'b0, 48'd0},
    // frozen LFO, delay set by the lower bound alone
    '{1'b1, REG_PHASE_STEP, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MANUAL_DELAY, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MOD_DEPTH, 31'd0, 48'd0, 1'b0, 48'd0},
    '{1'b1, REG_MIN_DELAY, 31'd512, 48'd0, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {24'sh0F0F0F, 24'shF0F0F0}, 1'b0, 48'd0},
    '{1'b0, REG_PHASE_STEP, 31'd0, {S_MIN, S_MIN}, 1'b0, 48'd0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [2*SampleBits-1:0] s_axis_tdata;   // left_in, right_in
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [2*SampleBits-1:0] m_axis_tdata;   // left_out, right_out
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;

  // predictor state and register copies
  bit   [PhaseW-1:0] lfo_phase;
  int                wr_pos;
  longint            delay_line [2][LineLen];
  int                sine_rom [SineEntries];
  bit   [StepW-1:0]  cfg_step;
  longint            cfg_depth;
  longint            cfg_manual;
  longint            cfg_min;
  longint            cfg_fb;
  longint            cfg_mix;

  stereo_t pending_frames [$];
  int      err_count   = 0;
  int      cycle_count = 0;
  bit      tx_steady   = 1'b0;
  bit      rx_steady   = 1'b0;

  stereo_flanger_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // quarter-wave entry k: odd polynomial in Q30, Horner form
  function automatic int sine_entry(int unsigned k);
    longint unsigned coef [4];
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned v;
    coef = '{64'd5026995, 64'd85569306, 64'd693598668, 64'd1686629713};
    x  = (64'(2 * k + 1) << 29) / SineEntries;
    x2 = (x * x) >> 30;
    r  = coef[0];
    for (int i = 1; i < 4; i++) r = coef[i] - ((r * x2) >> 30);
    v = (r * x) >> 30;
    v = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 32767 : int'(v);
  endfunction

  function automatic logic signed [SampleBits-1:0] clamp_sample(longint v);
    if (v > SampleHi) return S_MAX;
    if (v < SampleLo) return S_MIN;
    return v[SampleBits-1:0];
  endfunction

  // advances the LFO and both lines by one frame, returns the output frame
  function automatic stereo_t flange_frame(stereo_t x_in);
    longint  s;
    longint  modv;
    longint  dly;
    longint  pos;
    longint  mixv;
    longint  x;
    longint  a;
    longint  b;
    longint  wet;
    int      idx0;
    int      idx1;
    int      frac;
    int      sidx;
    int      ch;
    bit [1:0] quad;
    stereo_t y;
    lfo_phase = lfo_phase + PhaseW'(cfg_step);
    quad = lfo_phase[PhaseW-1 -: 2];
    sidx = int'(lfo_phase[PhaseW-3 -: SineBits]);
    if (quad[0]) sidx = SineEntries - 1 - sidx;
    s = quad[1] ? -longint'(sine_rom[sidx]) : longint'(sine_rom[sidx]);
    modv = (cfg_depth * (s + 32768)) >>> 16;
    dly = cfg_manual + modv;
    if (dly < cfg_min) dly = cfg_min;
    if (dly > DelayCap) dly = DelayCap;
    pos  = (longint'(wr_pos + LineLen) <<< 8) - dly;
    idx0 = int'((pos >>> 8) % LineLen);
    idx1 = (idx0 + 1) % LineLen;
    frac = int'(pos & 255);
    mixv = (cfg_mix > 65536) ? 65536 : cfg_mix;
    for (ch = 0; ch < 2; ch++) begin
      x   = (ch == 0) ? x_in.left : x_in.right;
      a   = delay_line[ch][idx0];
      b   = delay_line[ch][idx1];
      wet = (a * (256 - frac) + b * frac) >>> 8;
      // both taps are read before this frame's write
      delay_line[ch][wr_pos] = clamp_sample(x + ((wet * cfg_fb + 16384) >>> 15));
      if (ch == 0) begin
        y.left = clamp_sample((x * (65536 - mixv) + wet * mixv + 32768) >>> 16);
      end else begin
        y.right = clamp_sample((x * (65536 - mixv) + wet * mixv + 32768) >>> 16);
      end
    end
    wr_pos = (wr_pos + 1) % LineLen;
    return y;
  endfunction

  function automatic stereo_t draw_frame();
    logic signed [SampleBits-1:0] smp [2];
    for (int ch = 0; ch < 2; ch++) begin
      case ($urandom_range(0, 7))
        0:       smp[ch] = S_MAX;
        1:       smp[ch] = S_MIN;
        2:       smp[ch] = SampleBits'(int'($urandom_range(0, 511)) - 256);
        default: smp[ch] = SampleBits'($urandom);
      endcase
    end
    return {smp[1], smp[0]};
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // register writes only once every accepted frame has come out
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      REG_PHASE_STEP:   cfg_step   = d[StepW-1:0];
      REG_MOD_DEPTH:    cfg_depth  = d[DelayCfgW-1:0];
      REG_MANUAL_DELAY: cfg_manual = d[DelayCfgW-1:0];
      REG_MIN_DELAY:    cfg_min    = d[DelayCfgW-1:0];
      REG_FEEDBACK:     cfg_fb     = longint'(signed'(d[FbW-1:0]));
      REG_MIX:          cfg_mix    = d[MixW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(stereo_t d, bit typed, stereo_t want);
    int      gap;
    stereo_t model;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk_i) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= (2*SampleBits)'({$urandom, $urandom});
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    model = flange_frame(d);
    pending_frames.insert(pending_frames.size(), typed ? want : model);
  endtask

  task automatic run_phase(int frames);
    cfg_reg_e            r;
    logic [CfgDataW-1:0] val;
    int                  pick;
    int                  fbv;
    bit                  hold_style;
    stereo_t             held;
    r = r.first();
    do begin
      pick = $urandom_range(0, 7);
      case (r)
        REG_PHASE_STEP: begin
          val = (pick == 0) ? '0 : (pick == 1) ? CfgDataW'({StepW{1'b1}}) :
                (pick == 2) ? CfgDataW'($urandom) :
                CfgDataW'($urandom_range(0, 1 << 22));
        end
        REG_MOD_DEPTH, REG_MANUAL_DELAY: begin
          val = (pick == 0) ? '0 : (pick == 1) ? CfgDataW'({DelayCfgW{1'b1}}) :
                (pick == 2) ? CfgDataW'($urandom_range(0, 20'hFFFFF)) :
                CfgDataW'($urandom_range(0, 64 * 256));
        end
        REG_MIN_DELAY: begin
          val = (pick == 0) ? '0 : (pick == 1) ? CfgDataW'($urandom_range(0, 512)) :
                (pick == 2) ? CfgDataW'($urandom_range(0, 20'hFFFFF)) :
                CfgDataW'($urandom_range(0, 16 * 256));
        end
        REG_FEEDBACK: begin
          case (pick)
            0:       fbv = 31129;
            1:       fbv = -31129;
            2:       fbv = -32768;
            3:       fbv = 32767;
            default: fbv = int'($urandom_range(0, 62258)) - 31129;
          endcase
          val = CfgDataW'(fbv);
        end
        default: begin
          val = (pick == 0) ? '0 : (pick == 1) ? CfgDataW'(65536) :
                (pick == 2) ? CfgDataW'($urandom_range(65537, 131071)) :
                CfgDataW'($urandom_range(0, 65536));
        end
      endcase
      // now and then junk in the unused upper bits
      if ($urandom_range(0, 15) == 0) val = CfgDataW'($urandom);
      if ($urandom_range(0, 3) != 0) write_reg(r, val);
      r = r.next();
    end while (r != r.first());
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, CfgDataW'($urandom));
    end
    tx_steady  = ($urandom_range(0, 3) == 0);
    rx_steady  = ($urandom_range(0, 3) == 0);
    // held input drives the feedback loop into saturation
    hold_style = ($urandom_range(0, 3) == 0);
    held       = draw_frame();
    for (int k = 0; k < frames; k++) begin
      if (!hold_style || $urandom_range(0, 15) == 0) held = draw_frame();
      send_frame(held, 1'b0, '0);
    end
  endtask

  initial begin : sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : out_check
    stereo_t got;
    stereo_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_frames.size() == 0) begin
        flag_error($sformatf("output beat %h with no frame outstanding", m_axis_tdata));
      end else begin
        want = pending_frames.pop_front();
        if (got.left !== want.left) begin
          flag_error($sformatf("left got %0d expected %0d", got.left, want.left));
        end
        if (got.right !== want.right) begin
          flag_error($sformatf("right got %0d expected %0d", got.right, want.right));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PHASE_STEP;
    cfg_wdata_i   = '0;
    for (i = 0; i < SineEntries; i++) sine_rom[i] = sine_entry(i);
    lfo_phase  = '0;
    wr_pos     = 0;
    for (i = 0; i < LineLen; i++) begin
      delay_line[0][i] = 0;
      delay_line[1][i] = 0;
    end
    cfg_step   = StepW'(22370);
    cfg_depth  = 34406;
    cfg_manual = 18432;
    cfg_min    = 1229;
    cfg_fb     = 16384;
    cfg_mix    = 32768;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < DirRows; i++) begin
      if (DirectedSteps[i].is_cfg) begin
        write_reg(DirectedSteps[i].idx, DirectedSteps[i].wdata);
      end else begin
        send_frame(DirectedSteps[i].din, DirectedSteps[i].typed, DirectedSteps[i].dout);
      end
    end

    for (i = 0; i < PhaseCount; i++) run_phase(PhaseFrames);
    // one longer phase
    run_phase(WrapFrames);

    // sub-sample delay, then the longest delay
    write_reg(REG_MOD_DEPTH, '0);
    write_reg(REG_MIN_DELAY, '0);
    write_reg(REG_MANUAL_DELAY, CfgDataW'($urandom_range(0, 255)));
    for (i = 0; i < TailFrames; i++) send_frame(draw_frame(), 1'b0, '0);
    write_reg(REG_MANUAL_DELAY, {DelayCfgW{1'b1}});
    for (i = 0; i < TailFrames; i++) send_frame(draw_frame(), 1'b0, '0);

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
